// ===== rtl/core/plti_pkg.sv =====
package plti_pkg;

  localparam int MaxPoints = 32;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StArg   = 2'd1;
  localparam logic [1:0] StTable = 2'd2;

  localparam logic OpWrite   = 1'b0;
  localparam logic OpConvert = 1'b1;

  localparam logic [1:0] RegExtrap   = 2'd0;
  localparam logic [1:0] RegInUse    = 2'd1;
  localparam logic [1:0] RegExpected = 2'd2;
  localparam logic [1:0] RegUseMarks = 2'd3;

  // datapath operand selects
  typedef enum logic [1:0] {
    SelFirst  = 2'd0,
    SelSecond = 2'd1,
    SelPen    = 2'd2,
    SelLast   = 2'd3
  } sel_e;

  typedef struct packed {
    logic             wr_en;       // write a table point
    logic             rd_en;       // read entry rd_idx into the read registers
    logic [IdxW-1:0]  rd_idx;
    logic             ld_a;        // latch read data as point a
    logic             ld_b;        // latch read data as point b
    logic             lin_start;   // begin dx/dy/ds and multiply
    logic             div_step;    // one restoring division step
    logic             finish;      // form the signed, saturated result
  } dp_cmd_t;

  typedef struct packed {
    logic signed [31:0] rd_x;
    logic signed [31:0] rd_y;
    logic               dx_zero;
    logic               div_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/plti_ram.sv =====
module plti_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== rtl/core/plti_datapath.sv =====
module plti_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  plti_pkg::dp_cmd_t           cmd_i,
  input  logic [plti_pkg::IdxW-1:0]   wr_idx_i,
  input  logic signed [31:0]          wr_x_i,
  input  logic signed [31:0]          wr_y_i,
  input  logic signed [31:0]          sample_i,
  output plti_pkg::dp_stat_t          stat_o,
  output logic signed [31:0]          result_o
);
  import plti_pkg::*;

  localparam int ProdW = 66;
  localparam int DivN  = ProdW;

  logic [63:0] rd_data;
  logic signed [31:0] ax_q, ay_q, bx_q, by_q;
  logic [32:0] mds_q, mdy_q, d_q;
  logic        neg_q, neg_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [33:0] r_q, r_d;
  logic [41:0] q_q, q_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic signed [31:0] res_q, res_d;
  logic        mul_q;

  logic signed [32:0] dx, dy, ds;
  logic [34:0] rsh;
  logic [42:0] qsh;
  logic signed [43:0] sum;

  plti_ram #(.Width(64), .Depth(MaxPoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_idx_i),
    .wdata_i ({wr_y_i, wr_x_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_idx),
    .rdata_o (rd_data)
  );

  assign stat_o.rd_x = rd_data[31:0];
  assign stat_o.rd_y = rd_data[63:32];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      ax_q <= rd_data[31:0];
      ay_q <= rd_data[63:32];
    end
    if (cmd_i.ld_b) begin
      bx_q <= rd_data[31:0];
      by_q <= rd_data[63:32];
    end
  end

  assign dx = 33'(bx_q) - 33'(ax_q);
  assign dy = 33'(by_q) - 33'(ay_q);
  assign ds = 33'(sample_i) - 33'(ax_q);
  assign stat_o.dx_zero = (dx == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lin_start) begin
      mds_q <= ds[32] ? 33'(-ds) : 33'(ds);
      mdy_q <= dy[32] ? 33'(-dy) : 33'(dy);
      d_q   <= dx[32] ? 33'(-dx) : 33'(dx);
    end
  end

  assign rsh = {r_q, prod_q[ProdW-1]};
  assign qsh = {q_q, 1'b0};
  assign sum = 44'(ay_q) + (neg_q ? -44'(q_q) : 44'(q_q));

  // the cycle after lin_start multiplies, then one bit per step divides
  always_comb begin
    prod_d = prod_q;
    r_d    = r_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    res_d  = res_q;
    if (cmd_i.lin_start) begin
      neg_d  = (ds[32] ^ dy[32]) ^ dx[32];
      busy_d = 1'b0;
    end else if (mul_q) begin
      prod_d = ProdW'(mds_q * mdy_q);
      r_d    = '0;
      q_d    = '0;
      cnt_d  = 7'(DivN);
      busy_d = 1'b1;
    end else if (cmd_i.div_step && busy_q) begin
      prod_d = {prod_q[ProdW-2:0], 1'b0};
      if (rsh >= 35'(d_q)) begin
        r_d = 34'(rsh - 35'(d_q));
        q_d = 42'(qsh | 43'd1);
      end else begin
        r_d = rsh[33:0];
        q_d = 42'(qsh);
      end
      if (q_d > 42'(64'd1 << 40)) begin
        q_d = 42'(64'd1 << 40);
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
    if (cmd_i.finish) begin
      if (sum > 44'sh0007FFFFFFF) begin
        res_d = 32'h7FFFFFFF;
      end else if (sum < -44'sh00080000000) begin
        res_d = 32'h80000000;
      end else begin
        res_d = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      mul_q  <= cmd_i.lin_start;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    r_q    <= r_d;
    q_q    <= q_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  assign stat_o.div_done = !busy_q && !mul_q && !cmd_i.lin_start;
  assign result_o = res_q;
endmodule

// ===== rtl/core/plti_ctrl.sv =====
module plti_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [plti_pkg::IdxW-1:0]  idx_i,
  input  logic                       pvalid_i,
  input  logic signed [31:0]         sample_i,
  input  logic                       extrap_i,
  input  logic [5:0]                 in_use_i,
  input  logic [5:0]                 expected_i,
  input  logic                       use_marks_i,
  input  plti_pkg::dp_stat_t         stat_i,
  output plti_pkg::dp_cmd_t          cmd_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [1:0]                 res_status_o,
  output logic                       res_take_dp_o,
  output logic signed [31:0]         res_direct_o
);
  import plti_pkg::*;

  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SScan   = 11'b00000000010,
    SEnds   = 11'b00000000100,
    SRdA    = 11'b00000001000,
    SRdB    = 11'b00000010000,
    SLin    = 11'b00000100000,
    SDiv    = 11'b00001000000,
    SFin    = 11'b00010000000,
    SWalk   = 11'b00100000000,
    SWalkC  = 11'b01000000000,
    SOut    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [MaxPoints-1:0] marks_q, marks_d;
  logic [CntW-1:0] i_q, i_d, n_lim;
  logic [5:0] found_q, found_d;
  logic [IdxW-1:0] first_q, first_d, second_q, second_d, pen_q, pen_d, last_q, last_d;
  logic [IdxW-1:0] prev_q, prev_d, ra_q, ra_d, rb_q, rb_d;
  logic signed [31:0] fx_q, fx_d, px_q, px_d;
  logic [1:0] ph_q, ph_d;
  logic [1:0] st_q, st_d;
  logic take_q, take_d, ov_q, ov_d;
  logic signed [31:0] dir_q, dir_d;
  logic use_i;
  logic asc;

  assign n_lim = (in_use_i > 6'(MaxPoints)) ? CntW'(MaxPoints) : CntW'(in_use_i);
  assign use_i = !use_marks_i || marks_q[i_q[IdxW-1:0]];
  // read data holds the last point while the ends are compared
  assign asc = fx_q <= stat_i.rd_x;

  always_comb begin
    state_d = state_q; marks_d = marks_q; i_d = i_q; found_d = found_q;
    first_d = first_q; second_d = second_q; pen_d = pen_q; last_d = last_q;
    prev_d = prev_q; ra_d = ra_q; rb_d = rb_q; fx_d = fx_q;
    px_d = px_q; ph_d = ph_q; st_d = st_q; take_d = take_q; ov_d = ov_q;
    dir_d = dir_q;
    cmd_o = '0;
    in_ready_o = (state_q == SIdle);
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          st_d = StOk; take_d = 1'b0; dir_d = '0;
          if (op_i == OpWrite) begin
            cmd_o.wr_en = 1'b1;
            marks_d[idx_i] = pvalid_i;
            state_d = SOut;
          end else if (in_use_i == '0 || expected_i == '0) begin
            st_d = StArg;
            state_d = SOut;
          end else begin
            i_d = '0; found_d = '0;
            state_d = SScan;
          end
        end
      end
      SScan: begin
        if (i_q < n_lim && found_q < expected_i) begin
          if (use_i) begin
            if (found_q == '0) begin
              first_d = i_q[IdxW-1:0];
            end else begin
              if (found_q == 6'd1) second_d = i_q[IdxW-1:0];
              pen_d = last_q;
            end
            last_d = i_q[IdxW-1:0];
            found_d = found_q + 6'd1;
          end
          i_d = i_q + 1'b1;
        end else if (found_q != expected_i) begin
          st_d = StTable; state_d = SOut;
        end else begin
          ph_d = 2'd0; state_d = SEnds;
        end
      end
      // read first and last, then pick clamp, extrapolate or walk; a single point returns its y
      SEnds: begin
        cmd_o.rd_en = 1'b1;
        case (ph_q)
          2'd0: begin cmd_o.rd_idx = first_q; ph_d = 2'd1; end
          2'd1: begin
            cmd_o.rd_idx = last_q;
            fx_d = stat_i.rd_x; dir_d = stat_i.rd_y; ph_d = 2'd2;
            if (found_q == 6'd1) begin
              take_d = 1'b0; state_d = SOut;
            end
          end
          default: begin
            cmd_o.rd_en = 1'b0;
            ph_d = 2'd0;
            if ((asc && sample_i <= fx_q) || (!asc && sample_i >= fx_q)) begin
              if (extrap_i) begin
                ra_d = first_q; rb_d = second_q; state_d = SRdA;
              end else begin
                state_d = SOut;
              end
            end else if ((asc && sample_i >= stat_i.rd_x) ||
                         (!asc && sample_i <= stat_i.rd_x)) begin
              if (extrap_i) begin
                ra_d = pen_q; rb_d = last_q; state_d = SRdA;
              end else begin
                dir_d = stat_i.rd_y; state_d = SOut;
              end
            end else begin
              prev_d = first_q; px_d = fx_q;
              i_d = CntW'(first_q) + 1'b1; found_d = 6'd1;
              state_d = SWalk;
            end
          end
        endcase
      end
      SWalk: begin
        if (i_q < n_lim && found_q < expected_i) begin
          if (use_i) begin
            cmd_o.rd_en = 1'b1; cmd_o.rd_idx = i_q[IdxW-1:0];
            found_d = found_q + 6'd1;
            state_d = SWalkC;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          st_d = StTable; state_d = SOut;
        end
      end
      SWalkC: begin
        if ((sample_i >= px_q && sample_i <= stat_i.rd_x) ||
            (sample_i <= px_q && sample_i >= stat_i.rd_x)) begin
          ra_d = prev_q; rb_d = i_q[IdxW-1:0]; state_d = SRdA;
        end else begin
          prev_d = i_q[IdxW-1:0]; px_d = stat_i.rd_x;
          i_d = i_q + 1'b1; state_d = SWalk;
        end
      end
      SRdA: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_idx = ra_q; state_d = SRdB;
      end
      SRdB: begin
        cmd_o.ld_a = 1'b1;
        cmd_o.rd_en = 1'b1; cmd_o.rd_idx = rb_q; state_d = SLin;
      end
      SLin: begin
        cmd_o.ld_b = 1'b1;
        ov_d = 1'b0;
        state_d = SDiv;
        ph_d = 2'd0;
      end
      SDiv: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
          if (stat_i.dx_zero) begin
            st_d = StTable; state_d = SOut;
          end else begin
            cmd_o.lin_start = 1'b1;
          end
        end else begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_done) begin
            cmd_o.div_step = 1'b0;
            cmd_o.finish = 1'b1;
            state_d = SFin;
          end
        end
      end
      SFin: begin
        take_d = 1'b1; state_d = SOut;
      end
      SOut: begin
        if (res_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      marks_q <= '0;
      i_q <= '0; found_q <= '0; ph_q <= '0;
      st_q <= StOk; take_q <= 1'b0;
    end else begin
      state_q <= state_d;
      marks_q <= marks_d;
      i_q <= i_d; found_q <= found_d; ph_q <= ph_d;
      st_q <= st_d; take_q <= take_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d; second_q <= second_d; pen_q <= pen_d; last_q <= last_d;
    prev_q <= prev_d; ra_q <= ra_d; rb_q <= rb_d;
    fx_q <= fx_d; px_q <= px_d; ov_q <= ov_d; dir_q <= dir_d;
  end

  assign res_valid_o   = (state_q == SOut);
  assign res_status_o  = st_q;
  assign res_take_dp_o = take_q && !ov_q;
  assign res_direct_o  = (st_q == StOk) ? dir_q : '0;
endmodule

// ===== rtl/core/piecewise_linear_table_interp.sv =====
// Piecewise linear calibration table with signed Q16.16 points.
// Input beats on s_axis: op 0 stores one point (index, x, y, valid mark),
// op 1 converts sample_value through the table. Every input beat gives one
// beat on m_axis carrying status and converted_value.
// Configuration registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i;
// the user must write them only while the block is idle, as the block does not enforce this.
// One item is in flight at a time; s_axis_tready is high only while idle.
// A convert scans the table for valid points, then clamps at an end or extrapolates,
// or walks to the bracketing pair and interpolates, with a bit-serial divider
// stepping one quotient bit per cycle over the 66-bit product.
// The result is held on m_axis until taken; a stalled receiver stalls input.
// Reset clears valid marks and restores registers to their defaults;
// point coordinates are undefined until written.
module piecewise_linear_table_interp (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // point_index, point_x, point_y, point_valid,
                                      // sample_value, zero fill
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // status, converted_value, zero fill
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [5:0]   cfg_wdata_i
);
  import plti_pkg::*;

  logic extrap_q, marks_en_q;
  logic [5:0] in_use_q, expected_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic signed [31:0] dp_res, direct;
  logic signed [31:0] sample_q;
  logic [1:0] status;
  logic take_dp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extrap_q <= 1'b0;
      in_use_q <= 6'd32;
      expected_q <= 6'd32;
      marks_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegExtrap:   extrap_q <= cfg_wdata_i[0];
        RegInUse:    in_use_q <= cfg_wdata_i;
        RegExpected: expected_q <= cfg_wdata_i;
        RegUseMarks: marks_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // hold the sample of the accepted beat for the whole conversion
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata[101:70];
    end
  end

  plti_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser),
    .idx_i         (s_axis_tdata[IdxW-1:0]),
    .pvalid_i      (s_axis_tdata[69]),
    .sample_i      (sample_q),
    .extrap_i      (extrap_q),
    .in_use_i      (in_use_q),
    .expected_i    (expected_q),
    .use_marks_i   (marks_en_q),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_status_o  (status),
    .res_take_dp_o (take_dp),
    .res_direct_o  (direct)
  );

  plti_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .wr_idx_i (s_axis_tdata[IdxW-1:0]),
    .wr_x_i   (s_axis_tdata[36:5]),
    .wr_y_i   (s_axis_tdata[68:37]),
    .sample_i (sample_q),
    .stat_o   (stat),
    .result_o (dp_res)
  );

  assign m_axis_tdata = {6'd0, (status == StOk) ? (take_dp ? dp_res : direct) : 32'd0,
                         status};
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import plti_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [5:0]   cfg_wdata_i = '0;

  piecewise_linear_table_interp u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the table and registers
  logic signed [31:0] tbl_x [MaxPoints];
  logic signed [31:0] tbl_y [MaxPoints];
  logic               tbl_valid [MaxPoints];
  logic               extrap_q;
  logic [5:0]         in_use_q;
  logic [5:0]         expected_q;
  logic               use_marks_q;

  result_t pending_results [$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      hold_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic result_t line_through(int i, int j, longint s);
    result_t     r;
    longint      dx, dy, ds, q, sum;
    logic [127:0] prod;
    logic [127:0] den;
    logic        neg;
    r = '0;
    dx = longint'(tbl_x[j]) - longint'(tbl_x[i]);
    dy = longint'(tbl_y[j]) - longint'(tbl_y[i]);
    ds = s - longint'(tbl_x[i]);
    if (dx == 0) begin
      r.status = StTable;
      return r;
    end
    neg = ((ds < 0) != (dy < 0)) != (dx < 0);
    prod = 128'(ds < 0 ? -ds : ds) * 128'(dy < 0 ? -dy : dy);
    den = 128'(dx < 0 ? -dx : dx);
    prod = prod / den;
    // quotient saturates at 2^40, well past the output range
    q = (prod > 128'(64'd1 << 40)) ? (64'sd1 <<< 40) : longint'(prod[63:0]);
    sum = longint'(tbl_y[i]) + (neg ? -q : q);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.status = StOk;
    r.value = sum[31:0];
    return r;
  endfunction

  function automatic result_t convert_sample(longint s);
    result_t r;
    int      lim, i, first, second, pen, last, prev, found;
    logic    asc;
    r = '0;
    first = 0; second = 0; pen = 0; last = 0; found = 0;
    if (in_use_q == 0 || expected_q == 0) begin
      r.status = StArg;
      return r;
    end
    lim = (in_use_q > MaxPoints) ? MaxPoints : int'(in_use_q);
    for (i = 0; i < lim && found < expected_q; i++) begin
      if (use_marks_q && !tbl_valid[i]) continue;
      if (found == 0) first = i;
      else begin
        if (found == 1) second = i;
        pen = last;
      end
      last = i;
      found++;
    end
    if (found != expected_q) begin
      r.status = StTable;
      return r;
    end
    if (found == 1) begin
      r.value = tbl_y[first];
      return r;
    end
    asc = tbl_x[first] <= tbl_x[last];
    if ((asc && s <= tbl_x[first]) || (!asc && s >= tbl_x[first])) begin
      if (extrap_q) r = line_through(first, second, s);
      else r.value = tbl_y[first];
      if (r.status != StOk) r.value = '0;
      return r;
    end
    if ((asc && s >= tbl_x[last]) || (!asc && s <= tbl_x[last])) begin
      if (extrap_q) r = line_through(pen, last, s);
      else r.value = tbl_y[last];
      if (r.status != StOk) r.value = '0;
      return r;
    end
    prev = first;
    found = 1;
    for (i = first + 1; i < lim && found < expected_q; i++) begin
      if (use_marks_q && !tbl_valid[i]) continue;
      found++;
      if ((s >= tbl_x[prev] && s <= tbl_x[i]) || (s <= tbl_x[prev] && s >= tbl_x[i])) begin
        r = line_through(prev, i, s);
        if (r.status != StOk) r.value = '0;
        return r;
      end
      prev = i;
    end
    r.status = StTable;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_beat(logic op, int idx, logic [31:0] px, logic [31:0] py,
                           logic pv, logic [31:0] smp, int gap);
    result_t r;
    r = '0;
    if (op == OpWrite) s_axis_tdata <= {2'b00, 32'd0, pv, py, px, 5'(idx)};
    else s_axis_tdata <= {2'b00, smp, 1'b0, 32'd0, 32'd0, 5'd0};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OpWrite) begin
      tbl_x[idx] = px;
      tbl_y[idx] = py;
      tbl_valid[idx] = pv;
    end else begin
      r = convert_sample(longint'(signed'(smp)));
    end
    pending_results.push_back(r);
    items_sent++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(logic e, int n, int c, logic m);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= RegExtrap;   cfg_wdata_i <= 6'(e);
    @(posedge clk_i);
    cfg_addr_i <= RegInUse;    cfg_wdata_i <= 6'(n);
    @(posedge clk_i);
    cfg_addr_i <= RegExpected; cfg_wdata_i <= 6'(c);
    @(posedge clk_i);
    cfg_addr_i <= RegUseMarks; cfg_wdata_i <= 6'(m);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    extrap_q = e;
    in_use_q = 6'(n);
    expected_q = 6'(c);
    use_marks_q = m;
  endtask

  task automatic convert(logic [31:0] smp);
    send_beat(OpConvert, 0, '0, '0, 1'b0, smp, pick_gap());
  endtask

  task automatic store(int idx, logic [31:0] px, logic [31:0] py, logic pv);
    send_beat(OpWrite, idx, px, py, pv, $urandom, pick_gap());
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    set_regs(1'b0, 4, 4, 1'b0);
    store(0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    store(1, 32'h0000_0000, 32'h0001_0000, 1'b1);
    store(2, 32'h0001_0000, 32'h8000_0000, 1'b0);
    store(3, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    store(31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    convert(32'h8000_0000);           // low end, clamped
    convert(32'h7FFF_FFFF);           // high end, clamped
    convert(32'h0000_8000);           // inside, steep segment
    convert(32'h0000_0000);           // exactly on a point
    set_regs(1'b1, 4, 4, 1'b0);
    convert(32'h7FFF_FFFF);           // extrapolated at the top
    set_regs(1'b1, 4, 3, 1'b1);       // marks skip entry 2
    convert(32'h4000_0000);
    set_regs(1'b0, 0, 4, 1'b0);       // zero counts
    convert(32'h0000_1234);
    set_regs(1'b0, 4, 0, 1'b0);
    convert(32'h0000_1234);
    set_regs(1'b0, 4, 5, 1'b0);       // too few valid points
    convert(32'h0000_1234);
    set_regs(1'b0, 4, 1, 1'b0);       // single point
    convert(32'h0000_1234);
    store(1, 32'h8000_0000, 32'h0000_0005, 1'b1);
    set_regs(1'b1, 4, 4, 1'b0);       // equal x on the low end pair
    convert(32'h8000_0000);
    store(1, 32'h0000_0000, 32'h0001_0000, 1'b1);
  endtask

  task automatic test_random();
    int     n, neff, c, k, step_max, step, slack, cnt, pick;
    longint base, a, b, s;
    logic   e, m, desc;
    while (items_sent < 1500) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) n = $urandom_range(2, 5);
      else if (pick < 13) n = $urandom_range(6, 12);
      else if (pick < 16) n = 32;
      else if (pick < 17) n = $urandom_range(33, 63);
      else if (pick < 18) n = 1;
      else n = $urandom_range(0, 32);
      neff = (n > MaxPoints) ? MaxPoints : n;
      e = $urandom_range(0, 1);
      m = $urandom_range(0, 1);
      desc = $urandom_range(0, 1);
      step_max = (neff > 1) ? int'(32'hFFFF_FFFF / (neff - 1)) : 0;
      step = int'(32'($urandom_range(0, step_max)) >> $urandom_range(0, 24));
      slack = int'(32'hFFFF_FFFF - 32'(step) * 32'(neff > 0 ? neff - 1 : 0));
      base = desc ? 64'sd2147483647 - longint'($urandom_range(0, slack))
                  : -64'sd2147483648 + longint'($urandom_range(0, slack));
      cnt = 0;
      for (k = 0; k < neff; k++) begin
        a = desc ? base - longint'(k) * longint'(unsigned'(step))
                 : base + longint'(k) * longint'(unsigned'(step));
        if (k > 0 && $urandom_range(0, 29) == 0) a = tbl_x[k - 1];
        b = ($urandom_range(0, 2) == 0) ? longint'(signed'($urandom))
                                         : longint'($urandom_range(0, 65535)) - 32768;
        store(k, a[31:0], b[31:0], ($urandom_range(0, 4) != 0));
        if (!m || tbl_valid[k]) cnt++;
      end
      c = cnt;
      pick = $urandom_range(0, 19);
      if (pick == 0) c = cnt + 1;
      else if (pick == 1) c = 0;
      else if (pick < 4 && cnt > 1) c = $urandom_range(1, cnt - 1);
      set_regs(e, n, c, m);
      repeat ($urandom_range(10, 30)) begin
        pick = $urandom_range(0, 9);
        if (pick < 5 && neff > 1) begin
          k = $urandom_range(0, neff - 2);
          a = tbl_x[k];
          b = tbl_x[k + 1];
          s = a + ((b - a) * longint'($urandom_range(0, 1000))) / 1000;
        end else if (pick < 6 && neff > 0) begin
          s = tbl_x[$urandom_range(0, neff - 1)];
        end else if (pick < 8 && neff > 0) begin
          s = longint'(tbl_x[($urandom_range(0, 1) != 0) ? 0 : neff - 1])
              + longint'($urandom_range(0, 2000)) - 1000;
        end else if (pick < 9) begin
          s = longint'(signed'($urandom));
        end else begin
          // noise write outside the scanned range
          if (neff < MaxPoints)
            store($urandom_range(neff, MaxPoints - 1), $urandom, $urandom,
                  $urandom_range(0, 1));
          continue;
        end
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        convert(s[31:0]);
      end
    end
  endtask

  task automatic test_backpressure();
    set_regs(1'b1, 4, 4, 1'b0);
    hold_cycles = 400;
    repeat (8) send_beat(OpConvert, 0, '0, '0, 1'b0, $urandom, 0);
    wait_drained();
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (quiet_left > 0) begin
        m_axis_tready <= 1'b1;
        quiet_left--;
      end else begin
        case ($urandom_range(0, 199))
          0, 1:    begin quiet_left = $urandom_range(200, 800); m_axis_tready <= 1'b1; end
          2, 3, 4: begin stall_left = $urandom_range(20, 60); m_axis_tready <= 1'b0; end
          default: begin
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(0, 3);
            m_axis_tready <= (stall_left == 0);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker
  task automatic report_mismatch(string what, logic [39:0] want, logic [39:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %h got %h", what, want, got);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", '0, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.status)
          report_mismatch("status", 40'(want.status), 40'(m_axis_tdata[1:0]));
        if (m_axis_tdata[33:2] !== want.value)
          report_mismatch("converted_value", 40'(want.value), 40'(m_axis_tdata[33:2]));
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    for (int i = 0; i < MaxPoints; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_valid[i] = 1'b0;
    end
    extrap_q = 1'b0;
    in_use_q = 6'd32;
    expected_q = 6'd32;
    use_marks_q = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/plti_pkg.sv
rtl/core/plti_ram.sv
rtl/core/plti_datapath.sv
rtl/core/plti_ctrl.sv
rtl/core/piecewise_linear_table_interp.sv
verif/tb_top.sv
